### rtl/core/tsuie_pkg.sv
// Shared types and constants for the two-set union/intersection engine.
// Used by every module under rtl/core; depends on nothing else.
package tsuie_pkg;

    // Default number of entries in each list.
    localparam int unsigned SET_DEPTH_DEF = 32;

    // Width of one stored element.
    localparam int unsigned ELEM_W = 32;

    // Operation codes carried on the input op field.
    typedef enum logic [2:0] {
        OP_INS_A = 3'd0,
        OP_INS_B = 3'd1,
        OP_UNION = 3'd2,
        OP_ISECT = 3'd3,
        OP_COMPL = 3'd4
    } t_op;

    // Status codes of one result transaction.
    typedef enum logic [1:0] {
        ST_QUERY = 2'd0,
        ST_OK    = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // One result transaction as it travels to the output register.
    typedef struct packed {
        logic signed [ELEM_W-1:0] element;
        logic                     is_empty;
        t_status                  status;
        logic                     last;
    } t_result;

endpackage

### rtl/core/two_set_union_intersection_engine.sv
// Top level of the two-set union/intersection engine: sequencer and list counts.
// Depends on tsuie_pkg, tsuie_mem and tsuie_obuf.
//
//   Channel   Direction  Handshake                  Payload
//   input     sink       i_in_valid / o_in_stall    i_op, i_value
//   output    source     o_out_valid / i_out_stall  o_element, o_is_empty, o_status, o_last
//
// One input transaction is processed at a time; o_in_stall is high until its last
// result is in the output register. A query reads the source list entry by entry and
// compares each entry with the entries of the other list one at a time, set by the
// single read port of each list memory. Reset is synchronous and clears the counts
// and the sequencer, not the memories. A full output register stalls the sequencer
// only when it has a result to push.
module two_set_union_intersection_engine #(
    parameter int unsigned SET_DEPTH = tsuie_pkg::SET_DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [2:0]                             i_op,
    input  logic signed [tsuie_pkg::ELEM_W-1:0]    i_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [tsuie_pkg::ELEM_W-1:0]    o_element,
    output logic                                   o_is_empty,
    output logic [1:0]                             o_status,
    output logic                                   o_last
);

    localparam int unsigned AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int unsigned CW = $clog2(SET_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(SET_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACK,
        S_OREAD,
        S_OLATCH,
        S_INNER,
        S_EMIT,
        S_FINISH
    } t_state;

    t_state                        r_state, n_state;
    logic [CW-1:0]                 r_cnt_a, n_cnt_a;
    logic [CW-1:0]                 r_cnt_b, n_cnt_b;
    logic [CW-1:0]                 r_i, n_i;
    logic [CW-1:0]                 r_j, n_j;
    logic                          r_jv, n_jv;
    logic                          r_src_b, n_src_b;
    logic                          r_copy, n_copy;
    logic                          r_want, n_want;
    logic                          r_pv, n_pv;
    logic [tsuie_pkg::ELEM_W-1:0]  r_pend, n_pend;
    logic [tsuie_pkg::ELEM_W-1:0]  r_cand, n_cand;
    tsuie_pkg::t_status            r_ack, n_ack;

    logic                          in_acc;
    logic                          we_a, we_b;
    logic [AW-1:0]                 a_raddr, b_raddr;
    logic [tsuie_pkg::ELEM_W-1:0]  a_rdata, b_rdata;
    logic [tsuie_pkg::ELEM_W-1:0]  src_rdata, oth_rdata;
    logic [CW-1:0]                 src_cnt, oth_cnt;
    logic                          hit;
    logic                          push;
    tsuie_pkg::t_result            push_data;
    logic                          ob_ready;
    tsuie_pkg::t_result            ob_data;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    // Source and other list selection for the running query.
    assign src_cnt   = r_src_b ? r_cnt_b : r_cnt_a;
    assign oth_cnt   = r_src_b ? r_cnt_a : r_cnt_b;
    assign src_rdata = r_src_b ? b_rdata : a_rdata;
    assign oth_rdata = r_src_b ? a_rdata : b_rdata;
    assign a_raddr   = r_src_b ? r_j[AW-1:0] : r_i[AW-1:0];
    assign b_raddr   = r_src_b ? r_i[AW-1:0] : r_j[AW-1:0];
    assign hit       = r_jv && (oth_rdata == r_cand);

    // Inserts write only while idle and queries use read data only while busy, so no
    // read that a query uses meets a write to the same entry of a memory.
    assign we_a = in_acc && (i_op == tsuie_pkg::OP_INS_A) && (r_cnt_a != FULL_CNT);
    assign we_b = in_acc && (i_op == tsuie_pkg::OP_INS_B) && (r_cnt_b != FULL_CNT);

    tsuie_mem #(
        .DEPTH (SET_DEPTH),
        .AW    (AW)
    ) u_mem_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    tsuie_mem #(
        .DEPTH (SET_DEPTH),
        .AW    (AW)
    ) u_mem_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    // Sequencer next state. A found element waits in the pending register so
    // that the final one can be sent with last set.
    always_comb begin
        n_state   = r_state;
        n_cnt_a   = r_cnt_a;
        n_cnt_b   = r_cnt_b;
        n_i       = r_i;
        n_j       = r_j;
        n_jv      = r_jv;
        n_src_b   = r_src_b;
        n_copy    = r_copy;
        n_want    = r_want;
        n_pv      = r_pv;
        n_pend    = r_pend;
        n_cand    = r_cand;
        n_ack     = r_ack;
        push      = 1'b0;
        push_data = '{element: r_pend, is_empty: 1'b0,
                      status: tsuie_pkg::ST_QUERY, last: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_i  = '0;
                    n_pv = 1'b0;
                    case (i_op)
                        tsuie_pkg::OP_INS_A: begin
                            n_state = S_ACK;
                            if (r_cnt_a == FULL_CNT) begin
                                n_ack = tsuie_pkg::ST_FULL;
                            end else begin
                                n_ack   = tsuie_pkg::ST_OK;
                                n_cnt_a = r_cnt_a + CW'(1);
                            end
                        end
                        tsuie_pkg::OP_INS_B: begin
                            n_state = S_ACK;
                            if (r_cnt_b == FULL_CNT) begin
                                n_ack = tsuie_pkg::ST_FULL;
                            end else begin
                                n_ack   = tsuie_pkg::ST_OK;
                                n_cnt_b = r_cnt_b + CW'(1);
                            end
                        end
                        tsuie_pkg::OP_UNION: begin
                            n_state = S_OREAD;
                            n_src_b = 1'b1;
                            n_copy  = 1'b1;
                            n_want  = 1'b0;
                        end
                        tsuie_pkg::OP_ISECT: begin
                            n_state = S_OREAD;
                            n_src_b = 1'b0;
                            n_copy  = 1'b0;
                            n_want  = 1'b1;
                        end
                        tsuie_pkg::OP_COMPL: begin
                            n_state = S_OREAD;
                            n_src_b = 1'b1;
                            n_copy  = 1'b0;
                            n_want  = 1'b0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ACK: begin
                push      = 1'b1;
                push_data = '{element: '0, is_empty: 1'b0, status: r_ack, last: 1'b1};
                if (ob_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_OREAD: begin
                if (r_i >= src_cnt) begin
                    if (r_copy) begin
                        // Union: B has been copied, now filter A against B.
                        n_copy  = 1'b0;
                        n_src_b = 1'b0;
                        n_i     = '0;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    n_state = S_OLATCH;
                end
            end
            S_OLATCH: begin
                n_cand = src_rdata;
                if (r_copy) begin
                    n_state = S_EMIT;
                end else begin
                    n_j     = '0;
                    n_jv    = 1'b0;
                    n_state = S_INNER;
                end
            end
            S_INNER: begin
                // Compare the returned entry while the next read is issued.
                if (hit || (r_j >= oth_cnt)) begin
                    n_jv = 1'b0;
                    if (hit == r_want) begin
                        n_state = S_EMIT;
                    end else begin
                        n_i     = r_i + CW'(1);
                        n_state = S_OREAD;
                    end
                end else begin
                    n_j  = r_j + CW'(1);
                    n_jv = 1'b1;
                end
            end
            S_EMIT: begin
                push = r_pv;
                if (!r_pv || ob_ready) begin
                    n_pv    = 1'b1;
                    n_pend  = r_cand;
                    n_i     = r_i + CW'(1);
                    n_state = S_OREAD;
                end
            end
            S_FINISH: begin
                push = 1'b1;
                if (r_pv) begin
                    push_data.last = 1'b1;
                end else begin
                    push_data = '{element: '0, is_empty: 1'b1,
                                  status: tsuie_pkg::ST_QUERY, last: 1'b1};
                end
                if (ob_ready) begin
                    n_pv    = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer and count registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_pv    <= 1'b0;
            r_jv    <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_src_b <= 1'b0;
            r_copy  <= 1'b0;
            r_want  <= 1'b0;
            r_ack   <= tsuie_pkg::ST_QUERY;
        end else begin
            r_state <= n_state;
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_pv    <= n_pv;
            r_jv    <= n_jv;
            r_i     <= n_i;
            r_j     <= n_j;
            r_src_b <= n_src_b;
            r_copy  <= n_copy;
            r_want  <= n_want;
            r_ack   <= n_ack;
        end
        r_pend <= n_pend;
        r_cand <= n_cand;
    end

    tsuie_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_ready (ob_ready),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (ob_data)
    );

    assign o_element  = ob_data.element;
    assign o_is_empty = ob_data.is_empty;
    assign o_status   = ob_data.status;
    assign o_last     = ob_data.last;

    // A list count never passes the list depth.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= FULL_CNT) && (r_cnt_b <= FULL_CNT))
        else $error("list count exceeds depth");

    // No element is left pending once the sequencer is idle.
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pv)
        else $error("pending element left behind at idle");

    // An accepted insert is acknowledged from the next cycle on.
    a_ins_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && ((i_op == tsuie_pkg::OP_INS_A) || (i_op == tsuie_pkg::OP_INS_B)))
        |=> (r_state == S_ACK))
        else $error("insert not acknowledged");

    // An insert into list A that finds room grows its count by exactly one.
    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we_a |=> (r_cnt_a == $past(r_cnt_a) + CW'(1)))
        else $error("count of list A did not advance on insert");

endmodule

### rtl/core/tsuie_mem.sv
// Single list store: one write port and one read port, read data registered.
// Depends on tsuie_pkg for the element width.
module tsuie_mem #(
    parameter int unsigned DEPTH = tsuie_pkg::SET_DEPTH_DEF,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [AW-1:0]                   i_waddr,
    input  logic [tsuie_pkg::ELEM_W-1:0]    i_wdata,
    input  logic [AW-1:0]                   i_raddr,
    output logic [tsuie_pkg::ELEM_W-1:0]    o_rdata
);

    logic [tsuie_pkg::ELEM_W-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/core/tsuie_obuf.sv
// Output register that holds one result transaction until the sink takes it.
// Depends on tsuie_pkg for the result structure.
module tsuie_obuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tsuie_pkg::t_result i_data,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_stall,
    output tsuie_pkg::t_result o_data
);

    logic               r_valid;
    tsuie_pkg::t_result r_data;

    // The register can load when it is empty or being drained this cycle.
    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_push;
        end
    end

    // Payload holds while stalled.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_push) begin
            r_data <= i_data;
        end
    end

endmodule

### sim/tb_top.sv
// Self-checking testbench for the two-set union/intersection engine.
// Drives insert and query transactions with random idling and checks every result against
// the table's answer or a behavioral model of the two lists; depends on tsuie_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned DEPTH        = tsuie_pkg::SET_DEPTH_DEF;
    localparam int unsigned EW           = tsuie_pkg::ELEM_W;
    localparam int unsigned CLK_PERIOD   = 8;
    localparam int unsigned RESET_CYCLES = 11;
    localparam int unsigned RAND_ITEMS   = 130;
    localparam int unsigned CALM_ITEMS   = 30;
    localparam int unsigned HOLD_AT      = 30;
    localparam int unsigned PAUSE_AT     = 70;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned LIMIT_CYCLES = 1_200_000;

    // Op codes the engine ignores.
    localparam logic [2:0] OP_RSVD_5 = 3'd5;
    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;

    // Single-item answers that can be written down directly.
    localparam tsuie_pkg::t_result ANS_OK = '{element: '0, is_empty: 1'b0,
                                              status: tsuie_pkg::ST_OK, last: 1'b1};
    localparam tsuie_pkg::t_result ANS_FULL = '{element: '0, is_empty: 1'b0,
                                                status: tsuie_pkg::ST_FULL, last: 1'b1};
    localparam tsuie_pkg::t_result ANS_EMPTY = '{element: '0, is_empty: 1'b1,
                                                 status: tsuie_pkg::ST_QUERY, last: 1'b1};
    localparam tsuie_pkg::t_result ANS_MODEL = '{element: '0, is_empty: 1'b0,
                                                 status: tsuie_pkg::ST_QUERY, last: 1'b0};

    // One row of the directed table; typed rows carry their single answer.
    typedef struct packed {
        logic [2:0]           op;
        logic signed [EW-1:0] value;
        logic                 typed;
        tsuie_pkg::t_result   want;
    } t_stim_row;

    localparam int unsigned N_DIRECTED = 20;
    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        '{tsuie_pkg::OP_UNION, 32'sd0,        1'b1, ANS_EMPTY},
        '{tsuie_pkg::OP_ISECT, 32'sd0,        1'b1, ANS_EMPTY},
        '{tsuie_pkg::OP_COMPL, 32'sd0,        1'b1, ANS_EMPTY},
        '{tsuie_pkg::OP_INS_B, 32'sh7FFFFFFF, 1'b1, ANS_OK},
        '{tsuie_pkg::OP_INS_B, 32'sh80000000, 1'b1, ANS_OK},
        '{tsuie_pkg::OP_INS_B, 32'sd5,        1'b1, ANS_OK},
        '{tsuie_pkg::OP_INS_B, 32'sd5,        1'b1, ANS_OK},
        '{tsuie_pkg::OP_COMPL, 32'sd0,        1'b0, ANS_MODEL},
        '{tsuie_pkg::OP_UNION, -32'sd1,       1'b0, ANS_MODEL},
        '{tsuie_pkg::OP_ISECT, 32'sh7FFFFFFF, 1'b1, ANS_EMPTY},
        '{tsuie_pkg::OP_INS_A, 32'sd0,        1'b1, ANS_OK},
        '{tsuie_pkg::OP_INS_A, -32'sd1,       1'b1, ANS_OK},
        '{tsuie_pkg::OP_INS_A, 32'sd5,        1'b1, ANS_OK},
        '{tsuie_pkg::OP_INS_A, 32'sh80000000, 1'b1, ANS_OK},
        '{OP_RSVD_5,           -32'sd1,       1'b0, ANS_MODEL},
        '{OP_RSVD_6,           32'sd0,        1'b0, ANS_MODEL},
        '{OP_RSVD_7,           32'sh7FFFFFFF, 1'b0, ANS_MODEL},
        '{tsuie_pkg::OP_UNION, 32'sd0,        1'b0, ANS_MODEL},
        '{tsuie_pkg::OP_ISECT, 32'sd0,        1'b0, ANS_MODEL},
        '{tsuie_pkg::OP_COMPL, 32'sd0,        1'b0, ANS_MODEL}
    };

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic [2:0]           in_op     = tsuie_pkg::OP_INS_A;
    logic signed [EW-1:0] in_value  = '0;
    logic                 out_stall = 1'b0;

    wire                  in_stall;
    wire                  out_valid;
    wire signed [EW-1:0]  out_element;
    wire                  out_is_empty;
    wire [1:0]            out_status;
    wire                  out_last;

    // Model state: both lists and their fill counts.
    logic signed [EW-1:0] list_a [DEPTH];
    logic signed [EW-1:0] list_b [DEPTH];
    int unsigned          count_a = 0;
    int unsigned          count_b = 0;

    tsuie_pkg::t_result   answer_q [$];
    tsuie_pkg::t_result   pending_results [$];
    logic signed [EW-1:0] value_pool [8];
    int unsigned          err_count = 0;
    bit                   idle_on   = 1'b1;
    bit                   hold_req  = 1'b0;

    two_set_union_intersection_engine #(.SET_DEPTH(DEPTH)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_op        (in_op),
        .i_value     (in_value),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_element   (out_element),
        .o_is_empty  (out_is_empty),
        .o_status    (out_status),
        .o_last      (out_last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Linear search of list B (in_b set) or list A for one value.
    function automatic bit found_in(input bit in_b, input logic signed [EW-1:0] v);
        for (int unsigned i = 0; i < (in_b ? count_b : count_a); i++) begin
            if ((in_b ? list_b[i] : list_a[i]) === v) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void push_element(input logic signed [EW-1:0] v);
        answer_q.push_back(tsuie_pkg::t_result'{element: v, is_empty: 1'b0,
                                                status: tsuie_pkg::ST_QUERY, last: 1'b0});
    endfunction

    // Updates the lists for one input transaction and leaves its answer in answer_q.
    function automatic void predict_answer(input logic [2:0] op,
                                           input logic signed [EW-1:0] v);
        tsuie_pkg::t_result tail;
        answer_q.delete();
        case (op)
            tsuie_pkg::OP_INS_A: begin
                if (count_a >= DEPTH) begin
                    answer_q.push_back(ANS_FULL);
                end else begin
                    list_a[count_a] = v;
                    count_a++;
                    answer_q.push_back(ANS_OK);
                end
                return;
            end
            tsuie_pkg::OP_INS_B: begin
                if (count_b >= DEPTH) begin
                    answer_q.push_back(ANS_FULL);
                end else begin
                    list_b[count_b] = v;
                    count_b++;
                    answer_q.push_back(ANS_OK);
                end
                return;
            end
            tsuie_pkg::OP_UNION: begin
                for (int unsigned i = 0; i < count_b; i++) push_element(list_b[i]);
                for (int unsigned i = 0; i < count_a; i++) begin
                    if (!found_in(1'b1, list_a[i])) push_element(list_a[i]);
                end
            end
            tsuie_pkg::OP_ISECT: begin
                for (int unsigned i = 0; i < count_a; i++) begin
                    if (found_in(1'b1, list_a[i])) push_element(list_a[i]);
                end
            end
            tsuie_pkg::OP_COMPL: begin
                for (int unsigned i = 0; i < count_b; i++) begin
                    if (!found_in(1'b0, list_b[i])) push_element(list_b[i]);
                end
            end
            default: return;
        endcase
        // A query with nothing to say answers a single empty item.
        if (answer_q.size() == 0) begin
            answer_q.push_back(ANS_EMPTY);
        end else begin
            tail = answer_q.pop_back();
            tail.last = 1'b1;
            answer_q.push_back(tail);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Offers one input transaction and records its answer once it is taken.
    task automatic send_item(input logic [2:0] op, input logic signed [EW-1:0] v,
                             input logic typed, input tsuie_pkg::t_result want);
        @(negedge clk);
        in_valid <= 1'b1;
        in_op    <= op;
        in_value <= v;
        do @(posedge clk); while (in_stall);
        predict_answer(op, v);
        if (typed) begin
            pending_results.push_back(want);
        end else begin
            foreach (answer_q[i]) pending_results.push_back(answer_q[i]);
        end
    endtask

    // Drops valid for a random burst of cycles.
    task automatic sender_gap();
        int unsigned len;
        len = $urandom_range(1, 6);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (len - 1) @(negedge clk);
    endtask

    function automatic logic [2:0] pick_op();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) return tsuie_pkg::OP_INS_A;
        if (roll < 70) return tsuie_pkg::OP_INS_B;
        if (roll < 78) return tsuie_pkg::OP_UNION;
        if (roll < 86) return tsuie_pkg::OP_ISECT;
        if (roll < 95) return tsuie_pkg::OP_COMPL;
        case ($urandom_range(0, 2))
            0:       return OP_RSVD_5;
            1:       return OP_RSVD_6;
            default: return OP_RSVD_7;
        endcase
    endfunction

    // Half of the values come from a shared pool so that the lists overlap.
    function automatic logic signed [EW-1:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 6)) - 32'sd3;
            default: return value_pool[$urandom_range(0, 7)];
        endcase
    endfunction

    // Receiver: random stall bursts, plus one long hold on request.
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6) - 1) @(negedge clk);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Compare every accepted result transaction with the oldest expectation.
    always @(posedge clk) begin
        tsuie_pkg::t_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result element=%0d status=%0d",
                                          out_element, out_status));
            end else begin
                want = pending_results.pop_front();
                if (out_element !== want.element)
                    report_mismatch($sformatf("element got %0d want %0d",
                                              out_element, want.element));
                if (out_is_empty !== want.is_empty)
                    report_mismatch($sformatf("is_empty got %0b want %0b",
                                              out_is_empty, want.is_empty));
                if (out_status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              out_status, want.status));
                if (out_last !== want.last)
                    report_mismatch($sformatf("last got %0b want %0b",
                                              out_last, want.last));
            end
        end
    end

    // Stimulus: directed table, then random traffic, then drain.
    initial begin
        value_pool[0] = 32'sh80000000;
        value_pool[1] = 32'sh7FFFFFFF;
        value_pool[2] = 32'sd0;
        value_pool[3] = -32'sd1;
        for (int i = 4; i < 8; i++) value_pool[i] = $urandom;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++) begin
            send_item(DIRECTED[r].op, DIRECTED[r].value, DIRECTED[r].typed, DIRECTED[r].want);
            if (idle_on && $urandom_range(0, 3) == 0) sender_gap();
        end

        for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
            if (n == HOLD_AT) hold_req = 1'b1;
            if (n == PAUSE_AT) begin
                // Let the engine run dry before continuing.
                @(negedge clk);
                in_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge clk);
            end
            if (n == RAND_ITEMS - CALM_ITEMS) idle_on = 1'b0;
            send_item(pick_op(), pick_value(), 1'b0, ANS_MODEL);
            if (idle_on && $urandom_range(0, 3) == 0) sender_gap();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Hard stop if the engine hangs.
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### two_set_union_intersection_engine.f
rtl/core/tsuie_pkg.sv
rtl/core/tsuie_mem.sv
rtl/core/tsuie_obuf.sv
rtl/core/two_set_union_intersection_engine.sv
sim/tb_top.sv
